[src/rrop_pkg.sv]
// ----------------------------------------------------------------------------
// rrop_pkg
// Shared types, constants and the arc coefficient table for the rounded
// rectangle outline point generator.
// ----------------------------------------------------------------------------
package rrop_pkg;

    localparam int IN_DATA_W    = 160;   // 158 bits of fields, padded to bytes
    localparam int OUT_DATA_W   = 48;    // 47 bits of fields, padded to bytes
    localparam int CFG_W        = 4;
    localparam int COORD_W      = 23;    // internal coordinate width, no overflow
    localparam int POINT_W      = 21;
    localparam int PNUM_W       = 5;
    localparam int ARC_R_W      = 17;    // clamped radius, quarter of a 19-bit side
    localparam int K_W          = 16;
    localparam int PROD_W       = ARC_R_W + K_W;
    localparam int K_FRAC       = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int STEP_W       = 3;

    localparam logic [CFG_W-1:0]  SHARP_RESET = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ENTRY  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_EXIT   = 3'd5;

    localparam logic signed [POINT_W-1:0] POINT_MAX = 21'sd1048575;
    localparam logic signed [POINT_W-1:0] POINT_MIN = -21'sd1048576;

    typedef logic signed [COORD_W-1:0] t_coord;

    // outline order of the corners
    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } t_corner;

    // one classified rectangle, indexed by outline corner order
    typedef struct packed {
        t_coord                    left;
        t_coord                    top;
        t_coord                    right;
        t_coord                    bottom;
        t_coord [3:0]              cx;
        t_coord [3:0]              cy;
        logic   [3:0][ARC_R_W-1:0] arc_r;
        logic   [3:0]              sharp;
    } t_rect_rec;

    // cos 18, 36, 54, 72 degrees with 16 fraction bits
    function automatic logic [K_W-1:0] arc_k(input logic [1:0] idx);
        logic [K_W-1:0] k;
        case (idx)
            2'd0:    k = 16'd62328;
            2'd1:    k = 16'd53020;
            2'd2:    k = 16'd38521;
            default: k = 16'd20252;
        endcase
        return k;
    endfunction

endpackage

[src/rrop_front.sv]
// ----------------------------------------------------------------------------
// rrop_front
// Unpacks a rectangle beat, clamps the corner radii, classifies each corner
// as sharp or rounded and works out the corner centers.
// ----------------------------------------------------------------------------
module rrop_front
    import rrop_pkg::*;
(
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic [CFG_W-1:0]     i_sharp_threshold,
    output t_rect_rec            o_rec
);

    logic signed [19:0]   left_in;
    logic signed [19:0]   top_in;
    logic        [18:0]   width_in;
    logic        [18:0]   height_in;
    logic signed [19:0]   rq      [4];
    logic signed [19:0]   rc      [4];
    logic        [18:0]   min_side;
    logic [ARC_R_W-1:0]   limit;
    t_coord               rext;

    always_comb begin
        left_in   = i_data[19:0];
        top_in    = i_data[39:20];
        width_in  = i_data[58:40];
        height_in = i_data[77:59];
        rq[0]     = i_data[97:78];    // top-left
        rq[1]     = i_data[117:98];   // top-right
        rq[3]     = i_data[137:118];  // bottom-left, last in outline order
        rq[2]     = i_data[157:138];  // bottom-right

        min_side = (width_in < height_in) ? width_in : height_in;
        limit    = min_side[18:2];

        o_rec        = '0;
        o_rec.left   = t_coord'(left_in);
        o_rec.top    = t_coord'(top_in);
        o_rec.right  = t_coord'(left_in) + t_coord'({1'b0, width_in});
        o_rec.bottom = t_coord'(top_in) + t_coord'({1'b0, height_in});
        rext         = '0;

        for (int c = 0; c < 4; c++) begin
            rc[c] = (rq[c] > $signed({3'b0, limit})) ? $signed({3'b0, limit}) : rq[c];
            o_rec.sharp[c] = rc[c] < $signed({16'b0, i_sharp_threshold});
            o_rec.arc_r[c] = rc[c][ARC_R_W-1:0];
            rext = t_coord'(rc[c]);
            if (c == 0 || c == 3) begin
                o_rec.cx[c] = o_rec.left + rext;
            end else begin
                o_rec.cx[c] = o_rec.right - rext;
            end
            if (c == 0 || c == 1) begin
                o_rec.cy[c] = o_rec.top + rext;
            end else begin
                o_rec.cy[c] = o_rec.bottom - rext;
            end
        end
    end

endmodule

[src/rrop_queue.sv]
// ----------------------------------------------------------------------------
// rrop_queue
// Small register FIFO of classified rectangles between front and back end.
// ----------------------------------------------------------------------------
module rrop_queue
    import rrop_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH   // 2 or more
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rect_rec i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_rect_rec o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rect_rec          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[src/rrop_back.sv]
// ----------------------------------------------------------------------------
// rrop_back
// Walks the corners of the queued rectangle and generates one outline point
// per cycle unless stalled: issue/multiply stage, then round, add, saturate.
// ----------------------------------------------------------------------------
module rrop_back
    import rrop_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_rect_rec           i_q_data,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [POINT_W-1:0]  o_point_x,
    output logic [POINT_W-1:0]  o_point_y,
    output logic [PNUM_W-1:0]   o_point_number,
    output logic                o_last_point
);

    typedef struct packed {
        t_coord              base_x;
        t_coord              base_y;
        logic [PROD_W-1:0]   prod_x;
        logic [PROD_W-1:0]   prod_y;
        logic                neg_x;
        logic                neg_y;
        logic                arc;
        logic [PNUM_W-1:0]   pnum;
        logic                last;
    } t_stage_a;

    // sequencer
    t_corner             r_corner, n_corner;
    logic [STEP_W-1:0]   r_step,   n_step;
    logic [PNUM_W-1:0]   r_pnum,   n_pnum;

    // stage A (products) and output stage
    logic                r_a_valid;
    t_stage_a            r_a, n_a;
    logic                r_o_valid;
    logic [POINT_W-1:0]  r_o_x, n_o_x;
    logic [POINT_W-1:0]  r_o_y, n_o_y;
    logic [PNUM_W-1:0]   r_o_pnum;
    logic                r_o_last;

    logic                out_ready;
    logic                a_ready;
    logic                issue;
    logic                corner_done;
    logic                sharp;
    logic [ARC_R_W-1:0]  arc_r;
    t_coord              cx, cy, ent_x, ent_y, ext_x, ext_y;
    logic                x_use_b, y_use_b;
    logic [1:0]          kidx;
    logic [K_W-1:0]      ka, kb, kx, ky;
    logic [PROD_W:0]     rnd_x, rnd_y;
    logic signed [COORD_W:0] sum_x, sum_y;

    assign out_ready = !r_o_valid || i_ready;
    assign a_ready   = !r_a_valid || out_ready;
    assign issue     = i_q_valid && a_ready;

    assign sharp       = i_q_data.sharp[r_corner];
    assign arc_r       = i_q_data.arc_r[r_corner];
    assign cx          = i_q_data.cx[r_corner];
    assign cy          = i_q_data.cy[r_corner];
    assign corner_done = sharp ? (r_step == STEP_ENTRY) : (r_step == STEP_EXIT);
    assign o_q_pop     = issue && corner_done && (r_corner == CORNER_BL);

    // corner geometry: entry/exit points and which product feeds each axis
    always_comb begin
        ent_x = cx;  ent_y = cy;
        ext_x = cx;  ext_y = cy;
        x_use_b = 1'b0;  y_use_b = 1'b0;
        n_a = '0;
        unique case (r_corner)
            CORNER_TL: begin
                ent_x = i_q_data.left;   ent_y = cy;
                ext_x = cx;              ext_y = i_q_data.top;
                x_use_b = 1'b0;  n_a.neg_x = 1'b1;
                y_use_b = 1'b1;  n_a.neg_y = 1'b1;
            end
            CORNER_TR: begin
                ent_x = cx;              ent_y = i_q_data.top;
                ext_x = i_q_data.right;  ext_y = cy;
                x_use_b = 1'b1;  n_a.neg_x = 1'b0;
                y_use_b = 1'b0;  n_a.neg_y = 1'b1;
            end
            CORNER_BR: begin
                ent_x = i_q_data.right;  ent_y = cy;
                ext_x = cx;              ext_y = i_q_data.bottom;
                x_use_b = 1'b0;  n_a.neg_x = 1'b0;
                y_use_b = 1'b1;  n_a.neg_y = 1'b0;
            end
            CORNER_BL: begin
                ent_x = cx;              ent_y = i_q_data.bottom;
                ext_x = i_q_data.left;   ext_y = cy;
                x_use_b = 1'b1;  n_a.neg_x = 1'b1;
                y_use_b = 1'b0;  n_a.neg_y = 1'b0;
            end
            default: begin
                ent_x = cx;  ent_y = cy;
            end
        endcase

        // arc step s (1..4) uses table entries s-1 and 4-s
        kidx = 2'(r_step - 3'd1);
        ka   = arc_k(kidx);
        kb   = arc_k(~kidx);
        kx   = x_use_b ? kb : ka;
        ky   = y_use_b ? kb : ka;

        n_a.prod_x = {{K_W{1'b0}}, arc_r} * {{ARC_R_W{1'b0}}, kx};
        n_a.prod_y = {{K_W{1'b0}}, arc_r} * {{ARC_R_W{1'b0}}, ky};
        n_a.pnum   = r_pnum;
        n_a.last   = corner_done && (r_corner == CORNER_BL);

        if (sharp) begin
            n_a.base_x = cx;     n_a.base_y = cy;     n_a.arc = 1'b0;
        end else if (r_step == STEP_ENTRY) begin
            n_a.base_x = ent_x;  n_a.base_y = ent_y;  n_a.arc = 1'b0;
        end else if (r_step == STEP_EXIT) begin
            n_a.base_x = ext_x;  n_a.base_y = ext_y;  n_a.arc = 1'b0;
        end else begin
            n_a.base_x = cx;     n_a.base_y = cy;     n_a.arc = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_corner = r_corner;
        n_step   = r_step;
        n_pnum   = r_pnum;
        if (issue) begin
            if (corner_done) begin
                n_step = STEP_ENTRY;
                if (r_corner == CORNER_BL) begin
                    n_corner = CORNER_TL;
                    n_pnum   = '0;
                end else begin
                    n_corner = t_corner'(r_corner + 2'd1);
                    n_pnum   = r_pnum + 1'b1;
                end
            end else begin
                n_step = r_step + 1'b1;
                n_pnum = r_pnum + 1'b1;
            end
        end
    end

    // round to nearest, apply sign, saturate
    always_comb begin
        rnd_x = {1'b0, r_a.prod_x} + (PROD_W + 1)'(1 << (K_FRAC - 1));
        rnd_y = {1'b0, r_a.prod_y} + (PROD_W + 1)'(1 << (K_FRAC - 1));
        sum_x = (COORD_W + 1)'(r_a.base_x);
        sum_y = (COORD_W + 1)'(r_a.base_y);
        if (r_a.arc) begin
            if (r_a.neg_x) begin
                sum_x = sum_x - $signed({1'b0, rnd_x[PROD_W-1:K_FRAC]});
            end else begin
                sum_x = sum_x + $signed({1'b0, rnd_x[PROD_W-1:K_FRAC]});
            end
            if (r_a.neg_y) begin
                sum_y = sum_y - $signed({1'b0, rnd_y[PROD_W-1:K_FRAC]});
            end else begin
                sum_y = sum_y + $signed({1'b0, rnd_y[PROD_W-1:K_FRAC]});
            end
        end
        if (sum_x > (COORD_W + 1)'(POINT_MAX)) begin
            n_o_x = POINT_MAX;
        end else if (sum_x < (COORD_W + 1)'(POINT_MIN)) begin
            n_o_x = POINT_MIN;
        end else begin
            n_o_x = sum_x[POINT_W-1:0];
        end
        if (sum_y > (COORD_W + 1)'(POINT_MAX)) begin
            n_o_y = POINT_MAX;
        end else if (sum_y < (COORD_W + 1)'(POINT_MIN)) begin
            n_o_y = POINT_MIN;
        end else begin
            n_o_y = sum_y[POINT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner  <= CORNER_TL;
            r_step    <= STEP_ENTRY;
            r_pnum    <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_corner <= n_corner;
            r_step   <= n_step;
            r_pnum   <= n_pnum;
            if (a_ready) begin
                r_a_valid <= issue;
            end
            if (out_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a <= n_a;
        end
        if (out_ready && r_a_valid) begin
            r_o_x    <= n_o_x;
            r_o_y    <= n_o_y;
            r_o_pnum <= r_a.pnum;
            r_o_last <= r_a.last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_point_x      = r_o_x;
    assign o_point_y      = r_o_y;
    assign o_point_number = r_o_pnum;
    assign o_last_point   = r_o_last;

endmodule

[src/rounded_rect_outline_points_core.sv]
// ----------------------------------------------------------------------------
// rounded_rect_outline_points_core
// Rounded rectangle outline point generator, top level.
// ----------------------------------------------------------------------------
// Each input beat is one rectangle with four corner radii; the block returns
// its closed outline as a run of points, clockwise from the top-left corner,
// the final point flagged with tlast. A sharp corner yields one point and a
// rounded corner six, so a rectangle takes 4 to 24 output beats. The back end
// produces one point per cycle unless the output stalls, and that single
// point generator sets the rate. A small queue of classified rectangles sits
// between the front end and the back end, so new rectangles are taken while
// the previous outline is still streaming out. From idle, the first point
// passes through the queue, stage A and the output registers. All coordinates
// are signed fixed point with 4 fraction bits and saturate to 21 bits.
// ----------------------------------------------------------------------------
module rounded_rect_outline_points_core
    import rrop_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH   // rectangles buffered, 2 or more
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // rectangle beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: rect_left[19:0], rect_top[39:20], rect_width[58:40],
    // rect_height[77:59], radius_top_left[97:78], radius_top_right[117:98],
    // radius_bottom_left[137:118], radius_bottom_right[157:138], zero[159:158]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    // outline point beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: point_x[20:0], point_y[41:21], point_number[46:42],
    // zero[47]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // last_point

    // sharp_threshold write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0]   r_sharp_threshold;
    t_rect_rec          front_rec;
    t_rect_rec          q_head;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
    logic [PNUM_W-1:0]  point_number;

    // threshold register, writable any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sharp_threshold <= SHARP_RESET;
        end else if (i_cfg_valid) begin
            r_sharp_threshold <= i_cfg_data;
        end
    end

    // front end: clamp and classify in the accept cycle
    rrop_front u_front (
        .i_data            (s_axis_tdata),
        .i_sharp_threshold (r_sharp_threshold),
        .o_rec             (front_rec)
    );

    assign s_axis_tready = !q_full;

    rrop_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    // back end: one point per cycle unless the output stalls
    rrop_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_head),
        .o_q_pop        (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_point_x      (point_x),
        .o_point_y      (point_y),
        .o_point_number (point_number),
        .o_last_point   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, point_number, point_y, point_x};

endmodule
